/* src/assert_macros.svh */
// Assertion macros used by the checker module of the button press classifier.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bpc_pkg.sv */
// Types and constants for the button press classifier.
// No dependencies; imported by button_press_classifier, bpc_cfg_regs and bpc_core.
package bpc_pkg;

  localparam logic [2:0] ALL_RELEASED = 3'h7;
  localparam logic [4:0] LONG_FLAG    = 5'h10;

  localparam logic [7:0] DEBOUNCE_TICKS_RST   = 8'd5;
  localparam logic [7:0] LONG_PRESS_COUNT_RST = 8'd20;
  localparam logic [4:0] POWEROFF_CODE_RST    = 5'd17;
  localparam logic [4:0] SETUP_CODE_RST       = 5'd20;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE_TICKS   = 2'd0,
    CFG_LONG_PRESS_COUNT = 2'd1,
    CFG_POWEROFF_CODE    = 2'd2,
    CFG_SETUP_CODE       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] long_press_count;
    logic [4:0] poweroff_code;
    logic [4:0] setup_code;
  } cfg_t;

  typedef struct packed {
    logic       active;
    logic [4:0] message;
    logic       shutdown;
  } res_t;

endpackage

/* src/bpc_in_if.sv */
// Input channel of the button press classifier: one sample tick per transaction.
// No dependencies.
interface bpc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] button_levels;
  logic       take_message;

  modport source (output valid, output button_levels, output take_message, input ready);
  modport sink (input valid, input button_levels, input take_message, output ready);
endinterface

/* src/bpc_out_if.sv */
// Result channel of the button press classifier: one result per sample tick.
// No dependencies.
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic       active;
  logic [4:0] message;
  logic       shutdown;

  modport source (output valid, output active, output message, output shutdown, input ready);
  modport sink (input valid, input active, input message, input shutdown, output ready);
endinterface

/* src/button_press_classifier.sv */
// Top level of the button press classifier: input register, core, result register.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_cfg_regs and bpc_core.
//
//   Port      Direction  Contents
//   in_ch     sink       button_levels, take_message (one sample tick)
//   out_ch    source     active, message, shutdown (one result per tick)
//   cfg_*     input      write enable, register index, 8-bit write data
//
// One transaction is accepted per cycle while in_ch.ready is high; a result passes
// through the input register and then through the result register.
// The press state advances as a transaction leaves the input register.
// A stalled result holds both stages; in_ch.ready stays high while a stage is free.
// Reset is synchronous and clears both stages and all state.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bpc_in_if.sink     in_ch,
  bpc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_r;
  logic [2:0] s1_levels_r;
  logic       s1_take_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic       advance;
  logic       step;
  logic       accept;

  assign advance = out_ch.ready || !out_valid_r;
  assign step    = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign accept  = in_ch.valid && in_ch.ready;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .step          (step),
    .button_levels (s1_levels_r),
    .take_message  (s1_take_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_levels_r <= in_ch.button_levels;
      s1_take_r   <= in_ch.take_message;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.active   = out_res_r.active;
  assign out_ch.message  = out_res_r.message;
  assign out_ch.shutdown = out_res_r.shutdown;

endmodule

/* src/bpc_cfg_regs.sv */
// Configuration register file of the button press classifier.
// Depends on bpc_pkg.
module bpc_cfg_regs
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE_TICKS:   cfg_nxt.debounce_ticks   = cfg_wdata;
        CFG_LONG_PRESS_COUNT: cfg_nxt.long_press_count = cfg_wdata;
        CFG_POWEROFF_CODE:    cfg_nxt.poweroff_code    = cfg_wdata[4:0];
        CFG_SETUP_CODE:       cfg_nxt.setup_code       = cfg_wdata[4:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      cfg_r.long_press_count <= LONG_PRESS_COUNT_RST;
      cfg_r.poweroff_code    <= POWEROFF_CODE_RST;
      cfg_r.setup_code       <= SETUP_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/bpc_core.sv */
// Press classification state and its per-tick update logic.
// Depends on bpc_pkg.
module bpc_core
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [2:0] button_levels,
  input  logic       take_message,
  output res_t       res
);

  logic [2:0] pattern_r, pattern_nxt;
  logic [4:0] msg_r, msg_nxt;
  logic [8:0] hold_r, hold_nxt;
  logic       first_run_r, first_run_nxt;
  logic [7:0] cdown_r, cdown_nxt;

  logic [2:0] mask;
  logic       changed;

  always_comb begin
    pattern_nxt   = pattern_r;
    msg_nxt       = msg_r;
    hold_nxt      = hold_r;
    first_run_nxt = first_run_r;
    cdown_nxt     = (cdown_r != 8'd0) ? cdown_r - 8'd1 : cdown_r;
    res           = '0;
    changed       = (button_levels != pattern_r);
    mask          = 3'd0;

    if (changed) begin
      pattern_nxt   = button_levels;
      res.active    = 1'b1;
      first_run_nxt = 1'b0;
      hold_nxt      = 9'd0;
      cdown_nxt     = (button_levels == ALL_RELEASED) ? 8'd0 : cfg.debounce_ticks;
    end

    if (pattern_nxt != ALL_RELEASED) begin
      res.active = 1'b1;
      if (cdown_nxt == 8'd0) begin
        mask      = ~pattern_nxt;
        cdown_nxt = cfg.debounce_ticks;
        if (hold_nxt == 9'd0) begin
          msg_nxt = {2'b00, mask};
        end
        if (hold_nxt <= {1'b0, cfg.long_press_count}) begin
          hold_nxt = hold_nxt + 9'd1;
        end
        if (hold_nxt == {1'b0, cfg.long_press_count}) begin
          msg_nxt = LONG_FLAG | {2'b00, mask};
          if (!first_run_nxt) begin
            if (msg_nxt == cfg.poweroff_code) begin
              res.shutdown = 1'b1;
            end
            if (msg_nxt == cfg.setup_code) begin
              msg_nxt = 5'd0;
            end
          end
        end
      end
    end

    if (take_message) begin
      res.message = msg_nxt;
      msg_nxt     = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= ALL_RELEASED;
      msg_r       <= 5'd0;
      hold_r      <= 9'd1;
      first_run_r <= 1'b1;
      cdown_r     <= DEBOUNCE_TICKS_RST;
    end else if (step) begin
      pattern_r   <= pattern_nxt;
      msg_r       <= msg_nxt;
      hold_r      <= hold_nxt;
      first_run_r <= first_run_nxt;
      cdown_r     <= cdown_nxt;
    end
  end

endmodule

/* src/bpc_checker.sv */
// Port-level assertions for the button press classifier and their bind.
// Depends on assert_macros.svh and button_press_classifier.
`include "assert_macros.svh"

module bpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_active,
  input logic [4:0] out_message,
  input logic       out_shutdown
);

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_message) && $stable(out_active) && $stable(out_shutdown), "stalled result changed")
  `ASSERT_CLK(a_shutdown_active, out_valid && out_shutdown |-> out_active, "shutdown without a held button")
  `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with an empty result stage")
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_active   (out_ch.active),
  .out_message  (out_ch.message),
  .out_shutdown (out_ch.shutdown)
);
